/* hw/rtl/ips_pkg.sv */
// Shared types, codes and constants of the incubation phase sequencer.
`default_nettype none

package ips_pkg;

  // Incubator phases.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_PREHEAT  = 4'd1,
    PH_INCUBATE = 4'd2,
    PH_LOCKDOWN = 4'd3,
    PH_HATCH    = 4'd4,
    PH_DONE     = 4'd5,
    PH_PAUSED   = 4'd6,
    PH_ERROR    = 4'd7,
    PH_AUTOTUNE = 4'd8
  } phase_t;

  // Command codes carried by each request.
  typedef enum logic [4:0] {
    CMD_START       = 5'd0,
    CMD_INCUBATE    = 5'd1,
    CMD_LOCKDOWN    = 5'd2,
    CMD_HATCH       = 5'd3,
    CMD_DONE        = 5'd4,
    CMD_PAUSE       = 5'd5,
    CMD_RESUME      = 5'd6,
    CMD_ESTOP       = 5'd7,
    CMD_TUNE_START  = 5'd8,
    CMD_TUNE_END    = 5'd9,
    CMD_ERROR       = 5'd10,
    CMD_RECOVER     = 5'd11,
    CMD_RESET       = 5'd12,
    CMD_DAY_CHECK   = 5'd13,
    CMD_PREHEAT     = 5'd14,
    CMD_TEMP_OVR    = 5'd15,
    CMD_HUM_OVR     = 5'd16,
    CMD_CLEAR_OVR   = 5'd17
  } cmd_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP_SETPOINT    = 3'd0;
  localparam logic [2:0] REG_HUM_SETTER_LO    = 3'd1;
  localparam logic [2:0] REG_HUM_SETTER_HI    = 3'd2;
  localparam logic [2:0] REG_HUM_LOCKDOWN_LO  = 3'd3;
  localparam logic [2:0] REG_HUM_LOCKDOWN_HI  = 3'd4;
  localparam logic [2:0] REG_TURNING_STOP_DAY = 3'd5;
  localparam logic [2:0] REG_TOTAL_DAYS       = 3'd6;

  // Reset values.
  localparam logic [9:0]  RST_TEMP_SETPOINT    = 10'd375;
  localparam logic [6:0]  RST_HUM_SETTER_LO    = 7'd45;
  localparam logic [6:0]  RST_HUM_SETTER_HI    = 7'd55;
  localparam logic [6:0]  RST_HUM_LOCKDOWN_LO  = 7'd65;
  localparam logic [6:0]  RST_HUM_LOCKDOWN_HI  = 7'd75;
  localparam logic [9:0]  RST_TURNING_STOP_DAY = 10'd18;
  localparam logic [9:0]  RST_TOTAL_DAYS       = 10'd21;
  localparam logic [11:0] RST_TEMP_OVR_VAL     = 12'd375;

  // Stability band of the preheat check, tenths of a degree.
  localparam logic signed [12:0] STABLE_BAND = 13'sd5;

  // Configuration register file.
  typedef struct packed {
    logic [9:0] temp_setpoint;
    logic [6:0] hum_setter_lo;
    logic [6:0] hum_setter_hi;
    logic [6:0] hum_lockdown_lo;
    logic [6:0] hum_lockdown_hi;
    logic [9:0] turning_stop_day;
    logic [9:0] total_days;
  } ips_cfg_t;

  // Sequencer state carried from request to request.
  typedef struct packed {
    phase_t      phase;
    phase_t      saved_phase;
    logic        temp_ovr_on;
    logic [11:0] temp_ovr_val;
    logic        hum_ovr_on;
    logic [6:0]  hum_ovr_lo;
    logic [6:0]  hum_ovr_hi;
    logic [31:0] stable_ms;
  } ips_state_t;

  // One registered request.
  typedef struct packed {
    logic [4:0]  command;
    logic [9:0]  day_number;
    logic [11:0] measured_temp;
    logic [11:0] goal_temp;
    logic [15:0] elapsed_ms;
    logic [11:0] override_temp_value;
    logic [6:0]  override_lo_value;
    logic [6:0]  override_hi_value;
  } ips_req_t;

  // One result.
  typedef struct packed {
    logic        accepted;
    logic [3:0]  phase;
    logic        heating_allowed;
    logic        turning_allowed;
    logic [11:0] target_temp;
    logic [6:0]  hum_lo;
    logic [6:0]  hum_hi;
    logic [7:0]  hum_mid_x2;
    logic [31:0] stable_time_ms;
  } ips_res_t;

endpackage

`default_nettype wire

/* hw/rtl/ips_step.sv */
// Guarded phase transition logic for one command.
`default_nettype none

module ips_step (
  input  var ips_pkg::ips_state_t cur,
  input  var ips_pkg::ips_req_t   req,
  input  var ips_pkg::ips_cfg_t   cfg,
  output ips_pkg::ips_state_t     nxt,
  output logic                    ok
);
  import ips_pkg::*;

  logic               day_ge_stop;
  logic               day_ge_hatch;
  logic               day_ge_done;
  logic signed [12:0] temp_err;
  logic               in_band;
  logic [32:0]        stable_sum;
  logic [31:0]        stable_acc;

  // Day comparisons; day >= total - 1 is written as day + 1 >= total.
  assign day_ge_stop  = (req.day_number >= cfg.turning_stop_day);
  assign day_ge_hatch = ({1'b0, req.day_number} + 11'd1) >= {1'b0, cfg.total_days};
  assign day_ge_done  = {2'b00, req.day_number} >= ({2'b00, cfg.total_days} + 12'd2);

  // Preheat stability check and saturating accumulation.
  assign temp_err   = {req.measured_temp[11], req.measured_temp} -
                      {req.goal_temp[11], req.goal_temp};
  assign in_band    = (temp_err >= -STABLE_BAND) && (temp_err <= STABLE_BAND);
  assign stable_sum = {1'b0, cur.stable_ms} + {17'd0, req.elapsed_ms};
  assign stable_acc = stable_sum[32] ? 32'hFFFF_FFFF : stable_sum[31:0];

  // Apply the command's transition when its guard holds.
  always_comb begin
    nxt = cur;
    ok  = 1'b0;
    case (cmd_t'(req.command))
      CMD_START: begin
        if (cur.phase == PH_IDLE) begin
          nxt.phase     = PH_PREHEAT;
          nxt.stable_ms = '0;
          ok            = 1'b1;
        end
      end
      CMD_INCUBATE: begin
        if (cur.phase == PH_PREHEAT) begin
          nxt.phase = PH_INCUBATE;
          ok        = 1'b1;
        end
      end
      CMD_LOCKDOWN: begin
        if (cur.phase == PH_INCUBATE) begin
          nxt.phase = PH_LOCKDOWN;
          ok        = 1'b1;
        end
      end
      CMD_HATCH: begin
        if (cur.phase == PH_LOCKDOWN) begin
          nxt.phase = PH_HATCH;
          ok        = 1'b1;
        end
      end
      CMD_DONE: begin
        if (cur.phase == PH_HATCH) begin
          nxt.phase = PH_DONE;
          ok        = 1'b1;
        end
      end
      CMD_PAUSE: begin
        if (cur.phase == PH_INCUBATE || cur.phase == PH_LOCKDOWN ||
            cur.phase == PH_HATCH) begin
          nxt.saved_phase = cur.phase;
          nxt.phase       = PH_PAUSED;
          ok              = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (cur.phase == PH_PAUSED) begin
          nxt.phase = cur.saved_phase;
          ok        = 1'b1;
        end
      end
      CMD_ESTOP: begin
        nxt.saved_phase = cur.phase;
        nxt.phase       = PH_IDLE;
        ok              = 1'b1;
      end
      CMD_TUNE_START: begin
        if (cur.phase == PH_IDLE) begin
          nxt.phase = PH_AUTOTUNE;
          ok        = 1'b1;
        end
      end
      CMD_TUNE_END: begin
        if (cur.phase == PH_AUTOTUNE) begin
          nxt.phase = PH_IDLE;
          ok        = 1'b1;
        end
      end
      CMD_ERROR: begin
        nxt.saved_phase = cur.phase;
        nxt.phase       = PH_ERROR;
        ok              = 1'b1;
      end
      CMD_RECOVER: begin
        if (cur.phase == PH_ERROR) begin
          nxt.phase = cur.saved_phase;
          ok        = 1'b1;
        end
      end
      CMD_RESET: begin
        nxt.phase       = PH_IDLE;
        nxt.saved_phase = PH_IDLE;
        nxt.stable_ms   = '0;
        nxt.temp_ovr_on = 1'b0;
        nxt.hum_ovr_on  = 1'b0;
        ok              = 1'b1;
      end
      CMD_DAY_CHECK: begin
        if (cur.phase == PH_INCUBATE && day_ge_stop) begin
          nxt.phase = PH_LOCKDOWN;
          ok        = 1'b1;
        end else if (cur.phase == PH_LOCKDOWN && day_ge_hatch) begin
          nxt.phase = PH_HATCH;
          ok        = 1'b1;
        end else if (cur.phase == PH_HATCH && day_ge_done) begin
          nxt.phase = PH_DONE;
          ok        = 1'b1;
        end
      end
      CMD_PREHEAT: begin
        if (cur.phase == PH_PREHEAT) begin
          nxt.stable_ms = in_band ? stable_acc : '0;
          ok            = 1'b1;
        end
      end
      CMD_TEMP_OVR: begin
        nxt.temp_ovr_on  = 1'b1;
        nxt.temp_ovr_val = req.override_temp_value;
        ok               = 1'b1;
      end
      CMD_HUM_OVR: begin
        nxt.hum_ovr_on = 1'b1;
        nxt.hum_ovr_lo = req.override_lo_value;
        nxt.hum_ovr_hi = req.override_hi_value;
        ok             = 1'b1;
      end
      CMD_CLEAR_OVR: begin
        nxt.temp_ovr_on = 1'b0;
        nxt.hum_ovr_on  = 1'b0;
        ok              = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ips_result.sv */
// Result fields derived from the state after a command.
`default_nettype none

module ips_result (
  input  var ips_pkg::ips_state_t st,
  input  var ips_pkg::ips_cfg_t   cfg,
  input  var logic                ok,
  output ips_pkg::ips_res_t       res
);
  import ips_pkg::*;

  logic [6:0] lo;
  logic [6:0] hi;

  // Humidity band: override first, then lockdown presets, then setter presets.
  always_comb begin
    if (st.hum_ovr_on) begin
      lo = st.hum_ovr_lo;
      hi = st.hum_ovr_hi;
    end else if (st.phase == PH_LOCKDOWN || st.phase == PH_HATCH) begin
      lo = cfg.hum_lockdown_lo;
      hi = cfg.hum_lockdown_hi;
    end else begin
      lo = cfg.hum_setter_lo;
      hi = cfg.hum_setter_hi;
    end
  end

  // Assemble the result.
  always_comb begin
    res.accepted        = ok;
    res.phase           = st.phase;
    res.heating_allowed = (st.phase == PH_PREHEAT) || (st.phase == PH_INCUBATE) ||
                          (st.phase == PH_LOCKDOWN) || (st.phase == PH_HATCH) ||
                          (st.phase == PH_PAUSED) || (st.phase == PH_AUTOTUNE);
    res.turning_allowed = (st.phase == PH_INCUBATE);
    res.target_temp     = st.temp_ovr_on ? st.temp_ovr_val : {2'b00, cfg.temp_setpoint};
    res.hum_lo          = lo;
    res.hum_hi          = hi;
    res.hum_mid_x2      = {1'b0, lo} + {1'b0, hi};
    res.stable_time_ms  = st.stable_ms;
  end

endmodule

`default_nettype wire

/* hw/rtl/incubation_phase_sequencer.sv */
// Top level of the incubation phase sequencer: request register, step logic, result register.
// A request passes from the request register to the result register when that one is free.
// One request per cycle unless out_ready stalls; the state update is one pass of short logic.
// The result register lets a new request enter while a finished result waits.
// Reset (synchronous, active high) sets phase idle, clears overrides and stable time,
// empties both registers and restores the configuration presets.
`default_nettype none

module incubation_phase_sequencer (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration write port.
  input  wire logic                cfg_wr_en,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [9:0]          cfg_data,
  // Request channel.
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [4:0]          command,
  input  wire logic [9:0]          day_number,
  input  wire logic signed [11:0]  measured_temp,
  input  wire logic signed [11:0]  goal_temp,
  input  wire logic [15:0]         elapsed_ms,
  input  wire logic signed [11:0]  override_temp_value,
  input  wire logic [6:0]          override_lo_value,
  input  wire logic [6:0]          override_hi_value,
  // Result channel.
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     accepted,
  output logic [3:0]               phase,
  output logic                     heating_allowed,
  output logic                     turning_allowed,
  output logic signed [11:0]       target_temp_out,
  output logic [6:0]               humidity_lo_out,
  output logic [6:0]               humidity_hi_out,
  output logic [7:0]               humidity_mid_x2,
  output logic [31:0]              stable_time_ms
);
  import ips_pkg::*;

  ips_cfg_t   cfg;
  ips_state_t state;
  ips_state_t state_next;
  ips_req_t   req;
  logic       req_valid;
  logic       step_ok;
  ips_res_t   res_next;
  ips_res_t   res;
  logic       advance;

  // The request register moves into the result register when that one is free.
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_setpoint    <= RST_TEMP_SETPOINT;
      cfg.hum_setter_lo    <= RST_HUM_SETTER_LO;
      cfg.hum_setter_hi    <= RST_HUM_SETTER_HI;
      cfg.hum_lockdown_lo  <= RST_HUM_LOCKDOWN_LO;
      cfg.hum_lockdown_hi  <= RST_HUM_LOCKDOWN_HI;
      cfg.turning_stop_day <= RST_TURNING_STOP_DAY;
      cfg.total_days       <= RST_TOTAL_DAYS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TEMP_SETPOINT:    cfg.temp_setpoint    <= cfg_data;
        REG_HUM_SETTER_LO:    cfg.hum_setter_lo    <= cfg_data[6:0];
        REG_HUM_SETTER_HI:    cfg.hum_setter_hi    <= cfg_data[6:0];
        REG_HUM_LOCKDOWN_LO:  cfg.hum_lockdown_lo  <= cfg_data[6:0];
        REG_HUM_LOCKDOWN_HI:  cfg.hum_lockdown_hi  <= cfg_data[6:0];
        REG_TURNING_STOP_DAY: cfg.turning_stop_day <= cfg_data;
        REG_TOTAL_DAYS:       cfg.total_days       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.command             <= command;
      req.day_number          <= day_number;
      req.measured_temp       <= measured_temp;
      req.goal_temp           <= goal_temp;
      req.elapsed_ms          <= elapsed_ms;
      req.override_temp_value <= override_temp_value;
      req.override_lo_value   <= override_lo_value;
      req.override_hi_value   <= override_hi_value;
    end
  end

  // Transition logic and result formation.
  ips_step u_step (
    .cur (state),
    .req (req),
    .cfg (cfg),
    .nxt (state_next),
    .ok  (step_ok)
  );

  ips_result u_result (
    .st  (state_next),
    .cfg (cfg),
    .ok  (step_ok),
    .res (res_next)
  );

  // Sequencer state, committed as each request moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_IDLE;
      state.saved_phase  <= PH_IDLE;
      state.temp_ovr_on  <= 1'b0;
      state.temp_ovr_val <= RST_TEMP_OVR_VAL;
      state.hum_ovr_on   <= 1'b0;
      state.hum_ovr_lo   <= RST_HUM_SETTER_LO;
      state.hum_ovr_hi   <= RST_HUM_SETTER_HI;
      state.stable_ms    <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign accepted        = res.accepted;
  assign phase           = res.phase;
  assign heating_allowed = res.heating_allowed;
  assign turning_allowed = res.turning_allowed;
  assign target_temp_out = res.target_temp;
  assign humidity_lo_out = res.hum_lo;
  assign humidity_hi_out = res.hum_hi;
  assign humidity_mid_x2 = res.hum_mid_x2;
  assign stable_time_ms  = res.stable_time_ms;

  // Turning is only ever allowed in a phase that also allows heating.
  a_turn_implies_heat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!turning_allowed || heating_allowed))
    else $error("turning allowed without heating");

  // The midpoint field is the sum of the reported band limits.
  a_mid_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (humidity_mid_x2 == ({1'b0, humidity_lo_out} + {1'b0, humidity_hi_out})))
    else $error("humidity midpoint does not match band");

  // A full request register behind a stalled result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (req_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while pipeline is stalled");

  // State changes only when a request moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(state))
    else $error("state changed without a request");

endmodule

`default_nettype wire

/* tb/ips_phase_checker.sv */
// Checker for the incubation phase sequencer: mirrors the presets, predicts each result and compares.
module ips_phase_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [4:0]  command,
  input  logic [9:0]  day_number,
  input  logic [11:0] measured_temp,
  input  logic [11:0] goal_temp,
  input  logic [15:0] elapsed_ms,
  input  logic [11:0] override_temp_value,
  input  logic [6:0]  override_lo_value,
  input  logic [6:0]  override_hi_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        accepted,
  input  logic [3:0]  phase,
  input  logic        heating_allowed,
  input  logic        turning_allowed,
  input  logic [11:0] target_temp_out,
  input  logic [6:0]  humidity_lo_out,
  input  logic [6:0]  humidity_hi_out,
  input  logic [7:0]  humidity_mid_x2,
  input  logic [31:0] stable_time_ms,
  output int          fail_count,
  output int          pending
);
  import ips_pkg::*;

  // Mirrored presets and sequencer state.
  ips_cfg_t   presets;
  ips_state_t seq;
  ips_res_t   predicted_status[$];
  int         failures = 0;

  // Applies one command to the mirrored state and returns the status it should report.
  function automatic ips_res_t apply_command(input ips_req_t req);
    ips_res_t    res;
    logic        ok;
    int          meas;
    int          goal;
    int          err;
    logic [32:0] sum;
    logic [6:0]  lo;
    logic [6:0]  hi;
    ok = 1'b0;
    case (req.command)
      CMD_START: if (seq.phase == PH_IDLE) begin
        seq.phase = PH_PREHEAT;
        seq.stable_ms = '0;
        ok = 1'b1;
      end
      CMD_INCUBATE: if (seq.phase == PH_PREHEAT) begin
        seq.phase = PH_INCUBATE;
        ok = 1'b1;
      end
      CMD_LOCKDOWN: if (seq.phase == PH_INCUBATE) begin
        seq.phase = PH_LOCKDOWN;
        ok = 1'b1;
      end
      CMD_HATCH: if (seq.phase == PH_LOCKDOWN) begin
        seq.phase = PH_HATCH;
        ok = 1'b1;
      end
      CMD_DONE: if (seq.phase == PH_HATCH) begin
        seq.phase = PH_DONE;
        ok = 1'b1;
      end
      CMD_PAUSE: begin
        if (seq.phase == PH_INCUBATE || seq.phase == PH_LOCKDOWN ||
            seq.phase == PH_HATCH) begin
          seq.saved_phase = seq.phase;
          seq.phase = PH_PAUSED;
          ok = 1'b1;
        end
      end
      CMD_RESUME: if (seq.phase == PH_PAUSED) begin
        seq.phase = seq.saved_phase;
        ok = 1'b1;
      end
      CMD_ESTOP: begin
        seq.saved_phase = seq.phase;
        seq.phase = PH_IDLE;
        ok = 1'b1;
      end
      CMD_TUNE_START: if (seq.phase == PH_IDLE) begin
        seq.phase = PH_AUTOTUNE;
        ok = 1'b1;
      end
      CMD_TUNE_END: if (seq.phase == PH_AUTOTUNE) begin
        seq.phase = PH_IDLE;
        ok = 1'b1;
      end
      CMD_ERROR: begin
        seq.saved_phase = seq.phase;
        seq.phase = PH_ERROR;
        ok = 1'b1;
      end
      CMD_RECOVER: if (seq.phase == PH_ERROR) begin
        seq.phase = seq.saved_phase;
        ok = 1'b1;
      end
      CMD_RESET: begin
        seq.phase = PH_IDLE;
        seq.saved_phase = PH_IDLE;
        seq.stable_ms = '0;
        seq.temp_ovr_on = 1'b0;
        seq.hum_ovr_on = 1'b0;
        ok = 1'b1;
      end
      // Day thresholds compare as signed numbers, so a zero length makes hatching always due.
      CMD_DAY_CHECK: begin
        if (seq.phase == PH_INCUBATE &&
            int'(req.day_number) >= int'(presets.turning_stop_day)) begin
          seq.phase = PH_LOCKDOWN;
          ok = 1'b1;
        end else if (seq.phase == PH_LOCKDOWN &&
                     int'(req.day_number) >= int'(presets.total_days) - 1) begin
          seq.phase = PH_HATCH;
          ok = 1'b1;
        end else if (seq.phase == PH_HATCH &&
                     int'(req.day_number) >= int'(presets.total_days) + 2) begin
          seq.phase = PH_DONE;
          ok = 1'b1;
        end
      end
      // A sample inside the band adds to the stable time with saturation; outside it clears.
      CMD_PREHEAT: if (seq.phase == PH_PREHEAT) begin
        meas = $signed(req.measured_temp);
        goal = $signed(req.goal_temp);
        err = meas - goal;
        if (err < -5 || err > 5) begin
          seq.stable_ms = '0;
        end else begin
          sum = seq.stable_ms + req.elapsed_ms;
          seq.stable_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        ok = 1'b1;
      end
      CMD_TEMP_OVR: begin
        seq.temp_ovr_on = 1'b1;
        seq.temp_ovr_val = req.override_temp_value;
        ok = 1'b1;
      end
      CMD_HUM_OVR: begin
        seq.hum_ovr_on = 1'b1;
        seq.hum_ovr_lo = req.override_lo_value;
        seq.hum_ovr_hi = req.override_hi_value;
        ok = 1'b1;
      end
      CMD_CLEAR_OVR: begin
        seq.temp_ovr_on = 1'b0;
        seq.hum_ovr_on = 1'b0;
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase

    // Humidity comes from the override, then from the lockdown band, then from the setter band.
    if (seq.hum_ovr_on) begin
      lo = seq.hum_ovr_lo;
      hi = seq.hum_ovr_hi;
    end else if (seq.phase == PH_LOCKDOWN || seq.phase == PH_HATCH) begin
      lo = presets.hum_lockdown_lo;
      hi = presets.hum_lockdown_hi;
    end else begin
      lo = presets.hum_setter_lo;
      hi = presets.hum_setter_hi;
    end

    res.accepted = ok;
    res.phase = seq.phase;
    case (seq.phase)
      PH_PREHEAT, PH_INCUBATE, PH_LOCKDOWN, PH_HATCH, PH_PAUSED, PH_AUTOTUNE:
        res.heating_allowed = 1'b1;
      default: res.heating_allowed = 1'b0;
    endcase
    res.turning_allowed = (seq.phase == PH_INCUBATE);
    res.target_temp = seq.temp_ovr_on ? seq.temp_ovr_val : {2'b00, presets.temp_setpoint};
    res.hum_lo = lo;
    res.hum_hi = hi;
    res.hum_mid_x2 = {1'b0, lo} + {1'b0, hi};
    res.stable_time_ms = seq.stable_ms;
    return res;
  endfunction

  // Compares one field and reports a mismatch.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Watch the preset port and both channels at every edge.
  always @(posedge clk) begin
    ips_res_t want;
    ips_res_t got;
    if (rst) begin
      presets.temp_setpoint = RST_TEMP_SETPOINT;
      presets.hum_setter_lo = RST_HUM_SETTER_LO;
      presets.hum_setter_hi = RST_HUM_SETTER_HI;
      presets.hum_lockdown_lo = RST_HUM_LOCKDOWN_LO;
      presets.hum_lockdown_hi = RST_HUM_LOCKDOWN_HI;
      presets.turning_stop_day = RST_TURNING_STOP_DAY;
      presets.total_days = RST_TOTAL_DAYS;
      seq.phase = PH_IDLE;
      seq.saved_phase = PH_IDLE;
      seq.temp_ovr_on = 1'b0;
      seq.temp_ovr_val = RST_TEMP_OVR_VAL;
      seq.hum_ovr_on = 1'b0;
      seq.hum_ovr_lo = RST_HUM_SETTER_LO;
      seq.hum_ovr_hi = RST_HUM_SETTER_HI;
      seq.stable_ms = '0;
      predicted_status.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TEMP_SETPOINT:    presets.temp_setpoint = cfg_data;
          REG_HUM_SETTER_LO:    presets.hum_setter_lo = cfg_data[6:0];
          REG_HUM_SETTER_HI:    presets.hum_setter_hi = cfg_data[6:0];
          REG_HUM_LOCKDOWN_LO:  presets.hum_lockdown_lo = cfg_data[6:0];
          REG_HUM_LOCKDOWN_HI:  presets.hum_lockdown_hi = cfg_data[6:0];
          REG_TURNING_STOP_DAY: presets.turning_stop_day = cfg_data;
          REG_TOTAL_DAYS:       presets.total_days = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        predicted_status.push_back(apply_command({command, day_number, measured_temp,
            goal_temp, elapsed_ms, override_temp_value, override_lo_value,
            override_hi_value}));
      end

      if (out_valid && out_ready) begin
        got = {accepted, phase, heating_allowed, turning_allowed, target_temp_out,
               humidity_lo_out, humidity_hi_out, humidity_mid_x2, stable_time_ms};
        if (predicted_status.size() == 0) begin
          failures++;
          $error("status returned with no request outstanding");
        end else begin
          want = predicted_status.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("phase", want.phase, got.phase);
          check_field("heating_allowed", want.heating_allowed, got.heating_allowed);
          check_field("turning_allowed", want.turning_allowed, got.turning_allowed);
          check_field("target_temp_out", want.target_temp, got.target_temp);
          check_field("humidity_lo_out", want.hum_lo, got.hum_lo);
          check_field("humidity_hi_out", want.hum_hi, got.hum_hi);
          check_field("humidity_mid_x2", want.hum_mid_x2, got.hum_mid_x2);
          check_field("stable_time_ms", want.stable_time_ms, got.stable_time_ms);
        end
      end
    end
    pending <= predicted_status.size();
    fail_count <= failures;
  end

endmodule

/* tb/tb_incubation_phase_sequencer.sv */
// Testbench top: drives presets and requests into the phase sequencer and gives the verdict.
module tb_incubation_phase_sequencer;
  import ips_pkg::*;

  // Codes outside the command set, which the block must ignore.
  localparam logic [4:0] CMD_UNUSED_FIRST = 5'd18;
  localparam logic [4:0] CMD_UNUSED_LAST  = 5'd31;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [9:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [4:0]         command = '0;
  logic [9:0]         day_number = '0;
  logic signed [11:0] measured_temp = '0;
  logic signed [11:0] goal_temp = '0;
  logic [15:0]        elapsed_ms = '0;
  logic signed [11:0] override_temp_value = '0;
  logic [6:0]         override_lo_value = '0;
  logic [6:0]         override_hi_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               accepted;
  logic [3:0]         phase;
  logic               heating_allowed;
  logic               turning_allowed;
  logic signed [11:0] target_temp_out;
  logic [6:0]         humidity_lo_out;
  logic [6:0]         humidity_hi_out;
  logic [7:0]         humidity_mid_x2;
  logic [31:0]        stable_time_ms;
  int                 fail_count;
  int                 pending;

  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       counted_items = 0;
  ips_cfg_t active_cfg;

  incubation_phase_sequencer dut (.*);
  ips_phase_checker checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The status side stalls at random with the current stall rate.
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Hard limit on the run.
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // A request of the given command with every other field random over its full width.
  function automatic ips_req_t random_request(input logic [4:0] cmd);
    ips_req_t r;
    r.command = cmd;
    r.day_number = 10'($urandom_range(1023));
    r.measured_temp = 12'($urandom_range(4095));
    r.goal_temp = 12'($urandom_range(4095));
    r.elapsed_ms = 16'($urandom_range(65535));
    r.override_temp_value = 12'($urandom_range(4095));
    r.override_lo_value = 7'($urandom_range(127));
    r.override_hi_value = 7'($urandom_range(127));
    return r;
  endfunction

  // A preheat sample whose error lies within the given spread of the goal.
  function automatic ips_req_t near_sample(input int spread);
    ips_req_t r;
    int       goal;
    int       meas;
    r = random_request(CMD_PREHEAT);
    goal = int'($urandom_range(1650)) - 400;
    meas = goal + int'($urandom_range(2 * spread)) - spread;
    r.goal_temp = goal[11:0];
    r.measured_temp = meas[11:0];
    return r;
  endfunction

  // A day close to a threshold, or now and then any day at all.
  function automatic logic [9:0] day_near(input int base);
    int d;
    if ($urandom_range(3) == 0) begin
      d = $urandom_range(1023);
    end else begin
      d = base + int'($urandom_range(2)) - 1;
      if (d < 0) d = 0;
      if (d > 1023) d = 1023;
    end
    return d[9:0];
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic push_request(input ips_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= r.command;
    day_number <= r.day_number;
    measured_temp <= r.measured_temp;
    goal_temp <= r.goal_temp;
    elapsed_ms <= r.elapsed_ms;
    override_temp_value <= r.override_temp_value;
    override_lo_value <= r.override_lo_value;
    override_hi_value <= r.override_hi_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.command <= CMD_CLEAR_OVR) counted_items++;
  endtask

  // Sends a request, sometimes after a stray one that may break the sequence.
  task automatic issue(input ips_req_t r);
    if ($urandom_range(99) < 10) push_request(random_request(5'($urandom_range(31))));
    push_request(r);
  endtask

  task automatic issue_cmd(input cmd_t c);
    issue(random_request(c));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Writes every preset register and keeps a copy for the day thresholds.
  task automatic load_presets(input ips_cfg_t c);
    write_reg(REG_TEMP_SETPOINT, c.temp_setpoint);
    write_reg(REG_HUM_SETTER_LO, {3'b000, c.hum_setter_lo});
    write_reg(REG_HUM_SETTER_HI, {3'b000, c.hum_setter_hi});
    write_reg(REG_HUM_LOCKDOWN_LO, {3'b000, c.hum_lockdown_lo});
    write_reg(REG_HUM_LOCKDOWN_HI, {3'b000, c.hum_lockdown_hi});
    write_reg(REG_TURNING_STOP_DAY, c.turning_stop_day);
    write_reg(REG_TOTAL_DAYS, c.total_days);
    cfg_wr_en <= 1'b0;
    active_cfg = c;
  endtask

  function automatic ips_cfg_t make_cfg(input int temp, input int slo, input int shi,
                                        input int llo, input int lhi, input int turn,
                                        input int total);
    ips_cfg_t c;
    c.temp_setpoint = 10'(temp);
    c.hum_setter_lo = 7'(slo);
    c.hum_setter_hi = 7'(shi);
    c.hum_lockdown_lo = 7'(llo);
    c.hum_lockdown_hi = 7'(lhi);
    c.turning_stop_day = 10'(turn);
    c.total_days = 10'(total);
    return c;
  endfunction

  // Waits until every request sent so far has returned its status.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One incubation from start to finish with random content and stray requests.
  task automatic run_incubation();
    ips_req_t r;
    int       threshold[3];
    cmd_t     step_cmd[3];
    threshold[0] = int'(active_cfg.turning_stop_day);
    threshold[1] = int'(active_cfg.total_days) - 1;
    threshold[2] = int'(active_cfg.total_days) + 2;
    step_cmd[0] = CMD_LOCKDOWN;
    step_cmd[1] = CMD_HATCH;
    step_cmd[2] = CMD_DONE;

    // Leave whatever phase the previous run ended in.
    case ($urandom_range(3))
      0: issue_cmd(CMD_RESET);
      1: issue_cmd(CMD_ESTOP);
      2: begin
        issue_cmd(CMD_ERROR);
        issue_cmd(CMD_RECOVER);
        issue_cmd(CMD_ESTOP);
      end
      default: ;
    endcase
    if ($urandom_range(4) == 0) begin
      issue_cmd(CMD_TUNE_START);
      issue_cmd(CMD_TUNE_END);
    end

    // Preheat, mostly with samples in or just outside the stability band.
    issue_cmd(CMD_START);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(7) == 0) issue_cmd(CMD_PREHEAT);
      else issue(near_sample(6));
    end
    issue_cmd(CMD_INCUBATE);

    // Day checks walk toward each threshold; pauses and faults fall in between.
    for (int stage = 0; stage < 3; stage++) begin
      repeat ($urandom_range(1, 3)) begin
        r = random_request(CMD_DAY_CHECK);
        r.day_number = day_near(threshold[stage]);
        issue(r);
        if ($urandom_range(3) == 0) begin
          issue_cmd(CMD_PAUSE);
          if ($urandom_range(2) == 0) begin
            issue_cmd(CMD_ERROR);
            issue_cmd(CMD_RECOVER);
          end
          issue_cmd(CMD_RESUME);
        end
      end
      if ($urandom_range(1) == 0) issue_cmd(step_cmd[stage]);
      if ($urandom_range(9) < 3) issue_cmd(CMD_TEMP_OVR);
      if ($urandom_range(9) < 3) issue_cmd(CMD_HUM_OVR);
      if ($urandom_range(9) < 2) issue_cmd(CMD_CLEAR_OVR);
    end
  endtask

  task automatic random_phase(input int quota);
    counted_items = 0;
    while (counted_items < quota) run_incubation();
  endtask

  initial begin
    ips_req_t r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    load_presets(make_cfg(RST_TEMP_SETPOINT, RST_HUM_SETTER_LO, RST_HUM_SETTER_HI,
                          RST_HUM_LOCKDOWN_LO, RST_HUM_LOCKDOWN_HI,
                          RST_TURNING_STOP_DAY, RST_TOTAL_DAYS));

    // Directed requests: refusals in idle, band edges, an error during pause, overrides, unused codes.
    push_request(random_request(CMD_PREHEAT));
    push_request(random_request(CMD_DAY_CHECK));
    push_request(random_request(CMD_START));
    r = random_request(CMD_PREHEAT);
    r.goal_temp = 12'd0;
    r.measured_temp = 12'd5;
    r.elapsed_ms = 16'hFFFF;
    push_request(r);
    r.measured_temp = 12'hFFB;
    r.elapsed_ms = 16'd0;
    push_request(r);
    r.measured_temp = 12'd6;
    push_request(r);
    r.goal_temp = 12'h7FF;
    r.measured_temp = 12'h800;
    push_request(r);
    push_request(random_request(CMD_START));
    push_request(random_request(CMD_INCUBATE));
    r = random_request(CMD_DAY_CHECK);
    r.day_number = 10'd17;
    push_request(r);
    push_request(random_request(CMD_PAUSE));
    push_request(random_request(CMD_ERROR));
    push_request(random_request(CMD_RECOVER));
    push_request(random_request(CMD_RESUME));
    r = random_request(CMD_TEMP_OVR);
    r.override_temp_value = 12'h800;
    push_request(r);
    r = random_request(CMD_HUM_OVR);
    r.override_lo_value = 7'd127;
    r.override_hi_value = 7'd0;
    push_request(r);
    push_request(random_request(CMD_CLEAR_OVR));
    r = random_request(CMD_TEMP_OVR);
    r.override_temp_value = 12'h7FF;
    push_request(r);
    push_request(random_request(CMD_ESTOP));
    push_request(random_request(CMD_TUNE_START));
    push_request(random_request(CMD_TUNE_END));
    push_request(random_request(CMD_UNUSED_FIRST));
    push_request(random_request(CMD_UNUSED_LAST));
    push_request(random_request(CMD_RESET));

    // A run of stable preheat samples with near-maximum intervals.
    push_request(random_request(CMD_START));
    repeat (20) begin
      r = near_sample(0);
      r.elapsed_ms = 16'hFFFF - 16'($urandom_range(3));
      push_request(r);
    end
    push_request(near_sample(0));
    push_request(near_sample(5));

    // Random phases under different presets and idle patterns.
    wait_drained();
    load_presets(make_cfg(0, 0, 0, 0, 0, 0, 0));
    send_idle_pct = 69;
    recv_stall_pct = 0;
    random_phase(140);

    wait_drained();
    load_presets(make_cfg(1023, 127, 127, 127, 127, 1023, 1023));
    send_idle_pct = 0;
    recv_stall_pct = 69;
    random_phase(140);

    wait_drained();
    load_presets(make_cfg(1000, 0, 100, 100, 0, 1, 1));
    send_idle_pct = 11;
    recv_stall_pct = 11;
    random_phase(140);

    wait_drained();
    load_presets(make_cfg($urandom_range(1023), $urandom_range(127), $urandom_range(127),
                          $urandom_range(127), $urandom_range(127),
                          $urandom_range(40), $urandom_range(1, 40)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(140);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
